// ===== hw/rtl/serial_frame_builder_checksum_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the serial frame builder
// Shared concurrent check forms, clocked on the rising edge, masked in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_BUILDER_CHECKSUM_TOP_MACROS_SVH
`define SERIAL_FRAME_BUILDER_CHECKSUM_TOP_MACROS_SVH

// same-cycle implication
`define SFBC_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define SFBC_ASSERT_NXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hw/rtl/sfbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfbc_pkg
// Types and constants shared by the serial frame builder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfbc_pkg;

   localparam logic [7:0] SYNC0_BYTE = 8'hAA;
   localparam logic [7:0] SYNC1_BYTE = 8'h55;
   localparam logic [7:0] CR_BYTE    = 8'h0D;
   localparam logic [7:0] LF_BYTE    = 8'h0A;

   // byte slots of a job, in emit order
   localparam int NUM_SLOTS = 8;
   localparam logic [2:0] SLOT_SYNC0 = 3'd0;
   localparam logic [2:0] SLOT_SYNC1 = 3'd1;
   localparam logic [2:0] SLOT_PORT  = 3'd2;
   localparam logic [2:0] SLOT_LEN   = 3'd3;
   localparam logic [2:0] SLOT_DATA  = 3'd4;
   localparam logic [2:0] SLOT_SUM   = 3'd5;
   localparam logic [2:0] SLOT_CR    = 3'd6;
   localparam logic [2:0] SLOT_LF    = 3'd7;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;     // one bit per byte slot to emit
      logic [2:0]           port;
      logic [7:0]           payload_len;
      logic [7:0]           data_byte;
      logic [7:0]           checksum;
   } job_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sfbc_if.sv =====
// ----------------------------------------------------------------------------
// sfbc request and response channels
// Valid/ready channel interfaces for input items and output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfbc_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [2:0] port;
   logic [7:0] payload_len;
   logic       has_data;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, start_req, port, payload_len, has_data, data_byte, last,
                   input ready);
   modport sink   (input valid, start_req, port, payload_len, has_data, data_byte, last,
                   output ready);
endinterface

interface sfbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_end;

   modport source (output valid, out_byte, run_last, frame_end, input ready);
   modport sink   (input valid, out_byte, run_last, frame_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/serial_frame_builder_checksum_top.sv =====
// ----------------------------------------------------------------------------
// serial_frame_builder_checksum_top
// Frames serial payload bytes as AA 55 port len payload checksum CR LF.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  : one beat per input item (start_req, port, payload_len,
//              has_data, data_byte, last). Accepted when valid && ready.
//   rsp_bus  : one beat per output byte; run_last marks the final byte of
//              an item, frame_end marks the closing LF of a frame.
//   Each item yields 0 to 8 output beats: header (4) when it opens a frame,
//   its payload byte, then checksum, CR, LF when it closes the frame.
//   Idle items (no start, no data, no last) are taken and give nothing.
//   An item's first byte passes the job queue, job register and output register.
//   Throughput: one output byte per cycle while the receiver keeps rsp_bus
//   ready high, set by the single byte sequencer, so a stream of mid-frame
//   payload bytes runs at one item per cycle.
//   Reset (synchronous): no frame open, checksum cleared, queue empty.
//   Output stall: the output register holds; the 2-deep job queue absorbs
//   items until full, then req_bus ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_builder_checksum_top import sfbc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   sfbc_req_if.sink     req_bus,
   sfbc_rsp_if.source   rsp_bus
);

   // front -> queue
   logic    q_push;
   job_type q_push_job;
   logic    q_full;

   // queue -> back
   logic    q_pop;
   logic    q_head_valid;
   job_type q_head_job;

   // front: classifies the item, keeps frame state and running checksum
   sfbc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .q_full (q_full),
      .push   (q_push),
      .job    (q_push_job)
   );

   // short job queue so front and back stall on their own
   sfbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_job   (q_head_job)
   );

   // back: emits one framed byte per cycle through the output register while rsp is ready
   sfbc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_job   (q_head_job),
      .pop        (q_pop),
      .rsp        (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/sfbc_front.sv =====
// ----------------------------------------------------------------------------
// sfbc_front
// Accepts items, tracks the open frame and its checksum, builds byte jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module sfbc_front import sfbc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   sfbc_req_if.sink     req,
   input  wire logic    q_full,
   output logic         push,
   output job_type      job
);

   logic [7:0] sum_ff, sum_in;
   logic       open_ff, open_in;

   logic       accept;
   logic       start_eff;
   logic [7:0] hdr_sum;
   logic [7:0] base_sum;
   logic [7:0] cks;
   logic       emits;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_comb begin
      start_eff = req.start_req || (!open_ff && (req.has_data || req.last));
      hdr_sum   = SYNC0_BYTE + SYNC1_BYTE + {5'b0, req.port} + req.payload_len;
      base_sum  = start_eff ? hdr_sum : sum_ff;
      cks       = base_sum + (req.has_data ? req.data_byte : 8'h00);
      emits     = req.start_req || req.has_data || req.last;

      job.mask        = {{3{req.last}}, req.has_data, {4{start_eff}}};
      job.port        = req.port;
      job.payload_len = req.payload_len;
      job.data_byte   = req.data_byte;
      job.checksum    = cks;

      push = accept && emits;

      sum_in  = sum_ff;
      open_in = open_ff;
      if (accept && req.last) begin
         sum_in  = 8'h00;
         open_in = 1'b0;
      end else if (push) begin
         sum_in  = cks;
         open_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= 8'h00;
         open_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         open_ff <= open_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sfbc_queue.sv =====
// ----------------------------------------------------------------------------
// sfbc_queue
// Short job queue that decouples the front from the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_frame_builder_checksum_top_macros.svh"

module sfbc_queue import sfbc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output job_type      head_job
);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
      else                               r = p + 1'b1;
      return r;
   endfunction

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `SFBC_ASSERT_IMP(a_no_overflow, clock, reset, push, count_ff < QCNT_W'(QUEUE_DEPTH), "queue overflow")
   `SFBC_ASSERT_IMP(a_no_underflow, clock, reset, pop, count_ff != '0, "queue underflow")

endmodule

`default_nettype wire

// ===== hw/rtl/sfbc_back.sv =====
// ----------------------------------------------------------------------------
// sfbc_back
// Byte sequencer: walks each job's slots and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_frame_builder_checksum_top_macros.svh"

module sfbc_back import sfbc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire job_type head_job,
   output logic         pop,
   sfbc_rsp_if.source   rsp
);

   job_type              cur_ff, cur_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [NUM_SLOTS-1:0] rem_ff, rem_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 run_last_ff, run_last_in;
   logic                 frame_end_ff, frame_end_in;

   logic [2:0]           slot;
   logic [NUM_SLOTS-1:0] rem_clr;
   logic [7:0]           slot_byte;
   logic                 advance;
   logic                 fire;
   logic                 done;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_byte  = byte_ff;
   assign rsp.run_last  = run_last_ff;
   assign rsp.frame_end = frame_end_ff;

   always_comb begin
      // lowest pending slot goes out first
      slot = SLOT_LF;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (rem_ff[i]) slot = 3'(i);
      end
      rem_clr = rem_ff & ~(NUM_SLOTS'(1) << slot);

      case (slot)
         SLOT_SYNC0: slot_byte = SYNC0_BYTE;
         SLOT_SYNC1: slot_byte = SYNC1_BYTE;
         SLOT_PORT:  slot_byte = {5'b0, cur_ff.port};
         SLOT_LEN:   slot_byte = cur_ff.payload_len;
         SLOT_DATA:  slot_byte = cur_ff.data_byte;
         SLOT_SUM:   slot_byte = cur_ff.checksum;
         SLOT_CR:    slot_byte = CR_BYTE;
         SLOT_LF:    slot_byte = LF_BYTE;
         default:    slot_byte = LF_BYTE;
      endcase

      advance = !rsp_valid_ff || rsp.ready;
      fire    = cur_valid_ff && advance;
      done    = fire && (rem_clr == '0);
      pop     = head_valid && (!cur_valid_ff || done);

      cur_in       = pop ? head_job : cur_ff;
      cur_valid_in = pop ? 1'b1 : (done ? 1'b0 : cur_valid_ff);
      rem_in       = pop ? head_job.mask : (fire ? rem_clr : rem_ff);

      rsp_valid_in = fire ? 1'b1 : (advance ? 1'b0 : rsp_valid_ff);
      byte_in      = fire ? slot_byte : byte_ff;
      run_last_in  = fire ? (rem_clr == '0) : run_last_ff;
      frame_end_in = fire ? (slot == SLOT_LF) : frame_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      byte_ff      <= byte_in;
      run_last_ff  <= run_last_in;
      frame_end_ff <= frame_end_in;
   end

   `SFBC_ASSERT_IMP(a_end_closes_run, clock, reset, rsp_valid_ff && frame_end_ff, run_last_ff, "frame end without run end")
   `SFBC_ASSERT_IMP(a_end_is_lf, clock, reset, rsp_valid_ff && frame_end_ff, byte_ff == LF_BYTE, "frame end byte is not LF")
   `SFBC_ASSERT_IMP(a_job_nonempty, clock, reset, cur_valid_ff, rem_ff != '0, "active job has no bytes")

endmodule

`default_nettype wire

// ===== test/tb_serial_frame_builder_checksum_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial frame builder testbench
// Sends input items over the request channel with random gaps and takes output
// bytes with random stalls. A built-in frame predictor (header, payload,
// additive checksum, CR LF) queues the expected bytes, and every output beat
// is checked against the oldest one.
// ----------------------------------------------------------------------------

module tb_serial_frame_builder_checksum_top;
   import sfbc_pkg::*;

   localparam int MAX_WAIT         = 16;   // longest per-beat gap or stall
   localparam int LONG_HOLD_CYCLES = 200;  // receiver hold-off used to fill the queue
   localparam int DRAIN_CYCLES     = 20;   // settle time after the last expected byte
   localparam int RANDOM_ITEMS     = 140;
   localparam int MAX_REPORTS      = 10;

   // one input item as the request channel carries it
   typedef struct packed {
      logic       start_req;
      logic [2:0] port;
      logic [7:0] payload_len;
      logic       has_data;
      logic [7:0] data_byte;
      logic       last;
   } frame_item_type;

   // one output byte with its markers
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } frame_beat_type;

   logic clock = 1'b0;
   logic reset;

   sfbc_req_if req_bus ();
   sfbc_rsp_if rsp_bus ();

   serial_frame_builder_checksum_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // predictor state: mirrors the open frame and its running sum
   logic [7:0]     frame_sum;
   logic           frame_is_open;
   frame_beat_type expected_bytes[$];

   int  mismatch_count = 0;
   int  items_sent     = 0;   // items that do something (idle ones are not counted)
   bit  idling_on      = 1'b1;

   // receiver bookkeeping
   int  rsp_beats      = 0;   // bumped by the checker on every accepted beat
   int  rx_beats_noted = 0;
   int  rx_stall_left  = 0;
   int  hold_requests  = 0;   // bumped by a test to ask for a long hold-off
   int  holds_served   = 0;
   int  hold_left      = 0;

   // Per-beat wait, bounded by MAX_WAIT. At least a third of the draws are zero so
   // back-to-back runs show up even with idling on.
   function automatic int draw_wait();
      if (!idling_on) return 0;
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic frame_item_type make_item(input logic start_req, input logic [2:0] port,
                                                input logic [7:0] payload_len,
                                                input logic has_data,
                                                input logic [7:0] data_byte,
                                                input logic last);
      frame_item_type it;
      it.start_req   = start_req;
      it.port        = port;
      it.payload_len = payload_len;
      it.has_data    = has_data;
      it.data_byte   = data_byte;
      it.last        = last;
      return it;
   endfunction

   // queue one byte; everything queued counts toward the checksum
   function automatic void queue_frame_byte(input logic [7:0] value);
      frame_beat_type b;
      b.out_byte  = value;
      b.run_last  = 1'b0;
      b.frame_end = 1'b0;
      expected_bytes.push_back(b);
      frame_sum = frame_sum + value;
   endfunction

   // Works out the bytes one accepted item produces and appends them.
   // Data or last with no frame open acts as a start. Start during an open
   // frame drops it silently and restarts the sum.
   function automatic void predict_frame_bytes(input frame_item_type it);
      int         first_idx;
      logic       opening;
      logic [7:0] sum_out;
      first_idx = expected_bytes.size();
      opening   = it.start_req || (!frame_is_open && (it.has_data || it.last));
      if (opening) begin
         frame_sum     = 8'h00;
         frame_is_open = 1'b1;
         queue_frame_byte(SYNC0_BYTE);
         queue_frame_byte(SYNC1_BYTE);
         queue_frame_byte({5'b0, it.port});
         queue_frame_byte(it.payload_len);
      end
      if (frame_is_open && it.has_data)
         queue_frame_byte(it.data_byte);
      if (frame_is_open && it.last) begin
         sum_out = frame_sum;
         queue_frame_byte(sum_out);
         queue_frame_byte(CR_BYTE);
         queue_frame_byte(LF_BYTE);
         expected_bytes[$].frame_end = 1'b1;
         frame_sum     = 8'h00;
         frame_is_open = 1'b0;
      end
      if (expected_bytes.size() > first_idx)
         expected_bytes[$].run_last = 1'b1;
   endfunction

   // Drives one item at the falling edge after a random gap and holds it
   // until the block takes it. valid stays high afterward; the next call
   // either replaces the fields or drops valid for a gap.
   task automatic send_item(input frame_item_type it);
      int gap;
      gap = draw_wait();
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.start_req   <= it.start_req;
      req_bus.port        <= it.port;
      req_bus.payload_len <= it.payload_len;
      req_bus.has_data    <= it.has_data;
      req_bus.data_byte   <= it.data_byte;
      req_bus.last        <= it.last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_frame_bytes(it);
      if (it.start_req || it.has_data || it.last)
         items_sent++;
   endtask

   // sender goes quiet until every queued byte has come out
   task automatic wait_until_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   function automatic void report_mismatch(input string what, input logic [7:0] want,
                                           input logic [7:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: mismatch on %s: expected 0x%02h, got 0x%02h", $realtime, what,
                  want, got);
   endfunction

   // Result checker: every accepted output beat is compared with the oldest
   // expected byte, field by field.
   always @(posedge clock) begin : check_beat
      frame_beat_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         rsp_beats++;
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected beat, out_byte", 8'h00, rsp_bus.out_byte);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_bus.out_byte !== want.out_byte)
               report_mismatch("out_byte", want.out_byte, rsp_bus.out_byte);
            if (rsp_bus.run_last !== want.run_last)
               report_mismatch("run_last", {7'b0, want.run_last}, {7'b0, rsp_bus.run_last});
            if (rsp_bus.frame_end !== want.frame_end)
               report_mismatch("frame_end", {7'b0, want.frame_end}, {7'b0, rsp_bus.frame_end});
         end
      end
   end

   // Receiver: after each taken beat, stall a random number of cycles. A
   // long hold-off requested by a test overrides that and is counted here.
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left    = LONG_HOLD_CYCLES;
      end
      if (rsp_beats != rx_beats_noted) begin
         rx_beats_noted = rsp_beats;
         rx_stall_left  = draw_wait();
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Frame edges, field extremes and every special case of the framing.
   task automatic test_directed_cases();
      // idle with no frame open: nothing out
      send_item(make_item(1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b0));
      // last alone, nothing open: implicit start, empty frame
      send_item(make_item(1'b0, 3'd7, 8'hFF, 1'b0, 8'hFF, 1'b1));
      // explicit empty frame
      send_item(make_item(1'b1, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1));
      // frame whose header length disagrees with its payload; 0xFF bytes wrap the sum
      send_item(make_item(1'b1, 3'd7, 8'd3, 1'b1, 8'hFF, 1'b0));
      send_item(make_item(1'b0, 3'd2, 8'h11, 1'b1, 8'hFF, 1'b0));
      // idle inside an open frame
      send_item(make_item(1'b0, 3'd5, 8'h22, 1'b0, 8'h33, 1'b0));
      send_item(make_item(1'b0, 3'd0, 8'h00, 1'b1, 8'hFF, 1'b0));
      send_item(make_item(1'b0, 3'd0, 8'h00, 1'b1, 8'h00, 1'b1));
      // data with no frame open: implicit start with this item's port and length
      send_item(make_item(1'b0, 3'd3, 8'd1, 1'b1, 8'h5A, 1'b0));
      // start while open abandons the frame, twice
      send_item(make_item(1'b1, 3'd5, 8'd2, 1'b1, 8'h00, 1'b0));
      send_item(make_item(1'b1, 3'd1, 8'h80, 1'b0, 8'hC3, 1'b0));
      send_item(make_item(1'b0, 3'd4, 8'h7F, 1'b1, 8'h01, 1'b1));
      // whole frame in one item: eight bytes
      send_item(make_item(1'b1, 3'd6, 8'd1, 1'b1, 8'hAA, 1'b1));
      // trailing separate last after data
      send_item(make_item(1'b1, 3'd2, 8'd2, 1'b1, 8'h80, 1'b0));
      send_item(make_item(1'b0, 3'd0, 8'h00, 1'b1, 8'h7F, 1'b0));
      send_item(make_item(1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1));
   endtask

   // sender stops mid-frame until the output has caught up, then resumes
   task automatic test_sender_pause();
      send_item(make_item(1'b1, 3'd2, 8'd4, 1'b1, 8'h10, 1'b0));
      send_item(make_item(1'b0, 3'd0, 8'h00, 1'b1, 8'h20, 1'b0));
      wait_until_drained();
      send_item(make_item(1'b0, 3'd0, 8'h00, 1'b1, 8'h30, 1'b0));
      wait_until_drained();
      send_item(make_item(1'b0, 3'd0, 8'h00, 1'b1, 8'h40, 1'b1));
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering
   // back-to-back beats, so the job queue fills and req ready drops.
   task automatic test_output_backpressure();
      idling_on = 1'b0;
      hold_requests++;
      send_item(make_item(1'b1, 3'd3, 8'd40, 1'b1, 8'($urandom), 1'b0));
      for (int i = 0; i < 38; i++)
         send_item(make_item(1'b0, 3'($urandom), 8'($urandom), 1'b1, 8'($urandom), 1'b0));
      send_item(make_item(1'b0, 3'd0, 8'h00, 1'b1, 8'($urandom), 1'b1));
      idling_on = 1'b1;
   endtask

   // One well-formed frame with random content, in one of several shapes:
   // header on its own item or with the first byte, last on the final byte
   // or on an item of its own, sometimes abandoned without a last.
   task automatic send_random_frame();
      int         n;
      bit         header_alone;
      bit         abandon;
      bit         split_tail;
      logic [2:0] p;
      logic [7:0] len;
      n            = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      header_alone = ($urandom_range(0, 3) == 0);
      abandon      = ($urandom_range(0, 9) == 0);
      split_tail   = ($urandom_range(0, 3) == 0);
      p            = 3'($urandom_range(0, 7));
      len          = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(n);
      if (header_alone)
         send_item(make_item(1'b1, p, len, 1'b0, 8'($urandom), 1'b0));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0)
            send_item(make_item(1'b0, 3'($urandom), 8'($urandom), 1'b0, 8'($urandom), 1'b0));
         if (i == 0 && !header_alone)
            send_item(make_item(1'b1, p, len, 1'b1, 8'($urandom),
                                (n == 1) && !abandon && !split_tail));
         else
            send_item(make_item(1'b0, 3'($urandom), 8'($urandom), 1'b1, 8'($urandom),
                                (i == n - 1) && !abandon && !split_tail));
      end
      if (!abandon && (n == 0 || split_tail)) begin
         if (n == 0 && !header_alone)
            send_item(make_item(1'b1, p, len, 1'b0, 8'($urandom), 1'b1));
         else
            send_item(make_item(1'b0, 3'($urandom), 8'($urandom), 1'b0, 8'($urandom), 1'b1));
      end
   endtask

   // Mostly well-formed frames, some fully random items as noise. The first
   // half runs with no idling on either side, the second with idling.
   task automatic test_random_frames();
      int stop_at;
      stop_at   = items_sent + RANDOM_ITEMS;
      idling_on = 1'b0;
      while (items_sent < stop_at) begin
         if (items_sent > stop_at - RANDOM_ITEMS / 2)
            idling_on = 1'b1;
         if ($urandom_range(0, 99) < 85)
            send_random_frame();
         else
            send_item(make_item(1'($urandom), 3'($urandom), 8'($urandom), 1'($urandom),
                                8'($urandom), 1'($urandom)));
      end
      idling_on = 1'b1;
   endtask

   initial begin
      reset               = 1'b1;
      frame_sum           = 8'h00;
      frame_is_open       = 1'b0;
      req_bus.valid       = 1'b0;
      req_bus.start_req   = 1'b0;
      req_bus.port        = 3'd0;
      req_bus.payload_len = 8'h00;
      req_bus.has_data    = 1'b0;
      req_bus.data_byte   = 8'h00;
      req_bus.last        = 1'b0;
      rsp_bus.ready       = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_sender_pause();
      test_output_backpressure();
      test_random_frames();

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog: many times the slowest legal run
   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sfbc_pkg.sv
hw/rtl/sfbc_if.sv
hw/rtl/sfbc_front.sv
hw/rtl/sfbc_queue.sv
hw/rtl/sfbc_back.sv
hw/rtl/serial_frame_builder_checksum_top.sv
test/tb_serial_frame_builder_checksum_top.sv
